// ----- hw/rtl/assert_macros.svh -----
// Assertion macros included by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

// ----- hw/rtl/vpa_pkg.sv -----
// ----------------------------------------------------------------------------
// vpa_pkg
// Types, codes and defaults of the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;
	localparam int MaxBlocksDefault = 32;
	localparam int SizeBitsDefault  = 16;
	localparam int TagBits          = 8;
	localparam int IndexBits        = 5;
	localparam int CountBits        = 6;
	localparam int FieldSizeBits    = 16;
	localparam int CfgAddrBits      = 1;
	localparam int CfgDataBits      = 16;
	localparam logic [15:0] TotalSizeReset = 16'd1024;

	typedef enum logic [0:0] {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_NO_TAG   = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NONE  = 2'd3
	} fit_t;

	typedef enum logic [0:0] {
		CFG_FIT_POLICY = 1'b0,
		CFG_TOTAL_SIZE = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT_UP,
		S_WRITE_SPLIT,
		S_REL_SCAN,
		S_MERGE,
		S_SUM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [FieldSizeBits-1:0] request_size;
		logic [TagBits-1:0]       process_tag;
		func_t                    func;
	} request_t;

	typedef struct packed {
		logic [CountBits-1:0]     block_count;
		logic [FieldSizeBits-1:0] free_total;
		logic [IndexBits-1:0]     block_index;
		status_t                  status;
	} result_t;
endpackage

// ----- hw/rtl/vpa_stream_if.sv -----
// ----------------------------------------------------------------------------
// vpa_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface vpa_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/variable_partition_allocator.sv -----
// ----------------------------------------------------------------------------
// variable_partition_allocator
// First, best or worst fit allocator over an ordered table of partitions.
// ----------------------------------------------------------------------------
// The table of partitions lives in one synchronous memory of MAX_BLOCKS
// entries (size, free mark, owner). A request is handled one at a time by a
// sequencer that walks the memory one entry per cycle in its scan, release
// and summing passes. An allocate request takes a scan of the used entries,
// a shift of the tail for a split (each moved entry is read, then written),
// then a second pass that sums the free sizes. A free request releases and
// compacts in one pass that reads each entry once and writes the merged
// table back in place, followed by the summing pass. After reset, and after
// every write of total_size, a clearing pass over all MAX_BLOCKS entries
// rebuilds the table; no request is taken during it. The result is held in
// an output register, and the next request is taken only once it has been
// delivered.
`include "assert_macros.svh"

module variable_partition_allocator #(
	parameter int MAX_BLOCKS = vpa_pkg::MaxBlocksDefault,
	parameter int SIZE_BITS  = vpa_pkg::SizeBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	vpa_stream_if.sink                    req,
	vpa_stream_if.source                  rsp,
	input  logic                          cfg_we,
	input  logic [vpa_pkg::CfgAddrBits-1:0] cfg_index,
	input  logic [vpa_pkg::CfgDataBits-1:0] cfg_data
);
	import vpa_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	// One memory word: size, free mark and owner of one entry.
	typedef struct packed {
		logic [SIZE_BITS-1:0] size;
		logic                 free;
		logic [TagBits-1:0]   owner;
	} entry_t;

	entry_t mem [MAX_BLOCKS];
	entry_t rd_data;
	logic   rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	entry_t wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	// Registers.
	state_t state_q, state_d;
	fit_t   fit_q;
	logic [SIZE_BITS-1:0] total_q;
	logic [CW-1:0] used_q, used_d;
	logic [CW-1:0] rp_q, rp_d;         // read pointer
	logic [CW-1:0] wp_q, wp_d;         // write pointer
	logic          rv_q, rv_d;         // read data valid this cycle
	logic [CW-1:0] ri_q, ri_d;         // index of the data in rd_data
	request_t      cur_q;
	logic          found_q, found_d;
	logic [AW-1:0] pick_q, pick_d;
	logic [SIZE_BITS-1:0] psize_q, psize_d;
	entry_t        acc_q, acc_d;        // merge accumulator
	logic          acc_v_q, acc_v_d;
	logic [SIZE_BITS-1:0] sum_q, sum_d;
	status_t       st_q, st_d;
	logic          out_v_q;
	result_t       out_q;
	logic          init_req_q;

	logic req_fire, rsp_fire, cfg_total_wr;
	logic [SIZE_BITS-1:0] req_sz;
	logic fits, better;
	entry_t rel;

	assign req_fire     = req.valid && req.ready;
	assign rsp_fire     = rsp.valid && rsp.ready;
	assign cfg_total_wr = cfg_we && (cfg_index == CFG_TOTAL_SIZE);
	assign req.ready    = (state_q == S_IDLE) && !out_v_q && !init_req_q;
	assign rsp.valid    = out_v_q;
	assign rsp.payload  = out_q;

	assign req_sz = (SIZE_BITS >= FieldSizeBits)
		? SIZE_BITS'(cur_q.request_size) : cur_q.request_size[SIZE_BITS-1:0];
	assign fits = rd_data.free && (rd_data.size >= req_sz);

	always_comb begin
		case (fit_q)
			FIT_FIRST: better = !found_q;
			FIT_BEST:  better = !found_q || (rd_data.size < psize_q);
			FIT_WORST: better = !found_q || (rd_data.size > psize_q);
			default:   better = 1'b0;
		endcase
	end

	// Entry after release: used entries of the tag become free.
	always_comb begin
		rel = rd_data;
		if (!rd_data.free && rd_data.owner == cur_q.process_tag) begin
			rel.free  = 1'b1;
			rel.owner = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q      <= FIT_FIRST;
			total_q    <= SIZE_BITS'(TotalSizeReset);
			init_req_q <= 1'b1;
		end else begin
			if (cfg_we && cfg_index == CFG_FIT_POLICY) begin
				fit_q <= fit_t'(cfg_data[1:0]);
			end
			if (cfg_total_wr) begin
				total_q    <= (SIZE_BITS >= CfgDataBits)
					? SIZE_BITS'(cfg_data) : cfg_data[SIZE_BITS-1:0];
				init_req_q <= 1'b1;
			end else if (state_q == S_INIT) begin
				init_req_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			used_q  <= CW'(1);
			rp_q    <= '0;
			wp_q    <= '0;
			rv_q    <= 1'b0;
			out_v_q <= 1'b0;
			found_q <= 1'b0;
			acc_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			rv_q    <= rv_d;
			found_q <= found_d;
			acc_v_q <= acc_v_d;
			if (state_q == S_DONE) begin
				out_v_q <= 1'b1;
			end else if (rsp_fire) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ri_q    <= ri_d;
		pick_q  <= pick_d;
		psize_q <= psize_d;
		acc_q   <= acc_d;
		sum_q   <= sum_d;
		st_q    <= st_d;
		if (req_fire) begin
			cur_q <= req.payload;
		end
		if (state_q == S_DONE) begin
			out_q.status      <= st_q;
			out_q.block_index <= (st_q == ST_OK && cur_q.func == FUNC_ALLOC)
				? IndexBits'(pick_q) : '0;
			out_q.free_total  <= FieldSizeBits'(sum_q);
			out_q.block_count <= CountBits'(used_q);
		end
	end

	always_comb begin
		state_d = state_q;
		used_d  = used_q;
		rp_d    = rp_q;
		wp_d    = wp_q;
		rv_d    = 1'b0;
		ri_d    = rp_q;
		found_d = found_q;
		pick_d  = pick_q;
		psize_d = psize_q;
		acc_d   = acc_q;
		acc_v_d = acc_v_q;
		sum_d   = sum_q;
		st_d    = st_q;
		rd_en   = 1'b0;
		rd_addr = rp_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = wp_q[AW-1:0];
		wr_data = '0;
		case (state_q)
			S_INIT: begin
				// Clearing pass: entry 0 holds the whole size, others are empty.
				wr_en   = 1'b1;
				wr_addr = wp_q[AW-1:0];
				wr_data = '0;
				if (wp_q == '0) begin
					wr_data.size = total_q;
					wr_data.free = 1'b1;
				end
				used_d = CW'(1);
				if (cfg_total_wr) begin
					wp_d = '0;
				end else if (wp_q == CW'(MAX_BLOCKS - 1)) begin
					wp_d    = '0;
					state_d = S_IDLE;
				end else begin
					wp_d = wp_q + CW'(1);
				end
			end
			S_IDLE: begin
				if (init_req_q) begin
					wp_d    = '0;
					state_d = S_INIT;
				end else if (req_fire) begin
					rp_d    = '0;
					wp_d    = '0;
					found_d = 1'b0;
					acc_v_d = 1'b0;
					st_d    = ST_OK;
					state_d = (req.payload.func == FUNC_ALLOC) ? S_SCAN : S_REL_SCAN;
				end
			end
			S_SCAN: begin
				// Issue one read a cycle, judge the entry in the next cycle.
				if (rp_q < used_q) begin
					rd_en = 1'b1;
					rv_d  = 1'b1;
					rp_d  = rp_q + CW'(1);
				end
				if (rv_q && fits && better) begin
					found_d = 1'b1;
					pick_d  = ri_q[AW-1:0];
					psize_d = rd_data.size;
				end
				if (rp_q >= used_q && !rv_q) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!found_q) begin
					st_d    = ST_NO_FIT;
					rp_d    = '0;
					sum_d   = '0;
					state_d = S_SUM;
				end else if (psize_q > req_sz) begin
					if (used_q >= CW'(MAX_BLOCKS)) begin
						st_d    = ST_FULL;
						rp_d    = '0;
						sum_d   = '0;
						state_d = S_SUM;
					end else begin
						// Move the tail up by one, last entry first.
						rp_d    = used_q;
						state_d = S_SHIFT_UP;
					end
				end else begin
					wr_en   = 1'b1;
					wr_addr = pick_q;
					wr_data.size  = psize_q;
					wr_data.free  = 1'b0;
					wr_data.owner = cur_q.process_tag;
					rp_d    = '0;
					sum_d   = '0;
					state_d = S_SUM;
				end
			end
			S_SHIFT_UP: begin
				// rp_q is the destination; read rp_q-1, write it next cycle.
				if (rv_q) begin
					wr_en   = 1'b1;
					wr_addr = AW'(ri_q + CW'(1));
					wr_data = rd_data;
				end else if (rp_q > CW'(pick_q) + CW'(1)) begin
					rd_en   = 1'b1;
					rd_addr = AW'(rp_q - CW'(1));
					rv_d    = 1'b1;
					ri_d    = rp_q - CW'(1);
					rp_d    = rp_q - CW'(1);
				end else begin
					state_d = S_WRITE_SPLIT;
				end
			end
			S_WRITE_SPLIT: begin
				if (rp_q == CW'(pick_q) + CW'(1)) begin
					wr_en   = 1'b1;
					wr_addr = AW'(rp_q);
					wr_data.size = psize_q - req_sz;
					wr_data.free = 1'b1;
					rp_d = '0;
				end else begin
					wr_en   = 1'b1;
					wr_addr = pick_q;
					wr_data.size  = req_sz;
					wr_data.free  = 1'b0;
					wr_data.owner = cur_q.process_tag;
					used_d  = used_q + CW'(1);
					rp_d    = '0;
					sum_d   = '0;
					state_d = S_SUM;
				end
			end
			S_REL_SCAN: begin
				// Release and compact in one pass: accumulate runs of free
				// entries and write finished entries at the write pointer,
				// which never passes the read pointer.
				if (rp_q < used_q) begin
					rd_en = 1'b1;
					rv_d  = 1'b1;
					rp_d  = rp_q + CW'(1);
				end
				if (rv_q) begin
					if (rel.free != rd_data.free) begin
						found_d = 1'b1;
					end
					if (acc_v_q && acc_q.free && rel.free) begin
						acc_d.size = acc_q.size + rel.size;
					end else begin
						if (acc_v_q) begin
							wr_en   = 1'b1;
							wr_data = acc_q;
							wp_d    = wp_q + CW'(1);
						end
						acc_d   = rel;
						acc_v_d = 1'b1;
					end
				end
				if (rp_q >= used_q && !rv_q) begin
					state_d = S_MERGE;
				end
			end
			S_MERGE: begin
				// Last accumulated entry; a missing tag leaves the table as it was.
				if (!found_q) begin
					st_d = ST_NO_TAG;
				end else begin
					wr_en   = 1'b1;
					wr_data = acc_q;
					used_d  = wp_q + CW'(1);
				end
				rp_d    = '0;
				sum_d   = '0;
				state_d = S_SUM;
			end
			S_SUM: begin
				if (rp_q < used_q) begin
					rd_en = 1'b1;
					rv_d  = 1'b1;
					rp_d  = rp_q + CW'(1);
				end
				if (rv_q && rd_data.free) begin
					sum_d = sum_q + rd_data.size;
				end
				if (rp_q >= used_q && !rv_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	`ASSERT_IMPLIES(a_used_range, clk, arst_n, 1'b1,
		used_q >= CW'(1) && used_q <= CW'(MAX_BLOCKS))
	`ASSERT_IMPLIES(a_wp_behind, clk, arst_n, state_q == S_REL_SCAN, wp_q <= rp_q)
	`ASSERT_NEXT(a_out_after_done, clk, arst_n, state_q == S_DONE, rsp.valid)
	`ASSERT_IMPLIES(a_no_take_busy, clk, arst_n, req_fire, !out_v_q && state_q == S_IDLE)
endmodule
